### hdl/wbpd_pkg.sv
// wbpd_pkg: shared constants and elaboration-time helpers for the weighted bass peak detector.
// No dependencies; imported by wbpd_mul and weighted_bass_peak_detector.
`timescale 1ns / 1ps

package wbpd_pkg;

    // Operand width of the shared multiplier, product is twice this.
    localparam int MUL_W = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POSITION_STEP  = 2'd0;
    localparam logic [1:0] CFG_KICK_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_BOOST_GAIN     = 2'd2;

    // 0.3 in Q0.16 and the position ceiling (Q1.16).
    localparam logic [16:0] MID_Q16 = 17'd19661;
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // Reciprocal of 5 for the divide, result taken at bit 34.
    localparam logic [MUL_W-1:0] RECIP_5 = 32'hCCCCCCCD;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Ratio between table points, exp(-a) in Q2.30 from a 15-term Taylor series.
    // Every product is truncated.
    function automatic logic [63:0] exp_ratio(input logic [63:0] a);
        logic [63:0] term;
        logic [63:0] r;
        term = ONE_Q30;
        r    = ONE_Q30;
        term = (term * a) >> 30;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd2;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd3;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd4;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd5;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd6;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd7;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd8;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd9;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd10;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd11;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd12;
        r    = r + term;
        term = ((term * a) >> 30) / 64'd13;
        r    = (r >= term) ? r - term : 64'd0;
        term = ((term * a) >> 30) / 64'd14;
        r    = r + term;
        return r;
    endfunction

endpackage

### hdl/wbpd_mul.sv
// wbpd_mul: shared unsigned multiplier with a registered product.
// Depends on wbpd_pkg for the operand width.
`timescale 1ns / 1ps

module wbpd_mul
    import wbpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic [2*MUL_W-1:0]   o_prod
);

    logic [2*MUL_W-1:0] r_prod;

    // One multiply per cycle, product available the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hdl/weighted_bass_peak_detector.sv
// weighted_bass_peak_detector: per-bin Gaussian weighting, kick expansion, divide by 5
// and run peak tracking. Depends on wbpd_pkg and wbpd_mul.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-------------------------------
//  input   | in        | i_valid / o_stall        | i_amplitude, i_last_bin
//  output  | out       | o_valid / i_stall        | o_peak_value, o_saturated
//  config  | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A bin is accepted in S_IDLE; the next waits until the sequencer is back there: one shared
// multiplier runs every product in turn (square of distance, table scaling, interpolation,
// amplitude weight, excess square, gain in two halves, divide by 5).
// Far bins skip the table read; bins over the threshold add S_ESQ to S_BOOST for expansion.
// After reset the exp table is built in S_INIT_A and S_INIT_B, with o_stall high.
// A result waits in the output register; a last bin stalls only while it is full and stalled.
`timescale 1ns / 1ps

module weighted_bass_peak_detector
    import wbpd_pkg::*;
#(
    parameter int AMP_WIDTH       = 16,
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [AMP_WIDTH-1:0] i_amplitude,
    input  logic                 i_last_bin,
    // result words
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_peak_value,
    output logic                 o_saturated,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int TAB_N = EXP_TABLE_DEPTH + 1;
    localparam int VW    = (AMP_WIDTH > 16) ? AMP_WIDTH : 16;
    localparam int BW    = 2 * AMP_WIDTH + 8;
    localparam int SW    = BW + 1;
    localparam logic [63:0] EXP_STEP_Q30  = (64'd16 << 30) / EXP_TABLE_DEPTH;
    localparam logic [63:0] EXP_RATIO_Q30 = exp_ratio(EXP_STEP_Q30);
    localparam logic [AMP_WIDTH-1:0] VAL_MAX = {AMP_WIDTH{1'b1}};

    // sequencer states
    localparam logic [3:0] S_INIT_A = 4'd0;
    localparam logic [3:0] S_INIT_B = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_SCALE  = 4'd3;
    localparam logic [3:0] S_IDX    = 4'd4;
    localparam logic [3:0] S_RDHI   = 4'd5;
    localparam logic [3:0] S_RDLO   = 4'd6;
    localparam logic [3:0] S_INTERP = 4'd7;
    localparam logic [3:0] S_AMP    = 4'd8;
    localparam logic [3:0] S_VAL    = 4'd9;
    localparam logic [3:0] S_ESQ    = 4'd10;
    localparam logic [3:0] S_GLO    = 4'd11;
    localparam logic [3:0] S_GHI    = 4'd12;
    localparam logic [3:0] S_BOOST  = 4'd13;
    localparam logic [3:0] S_DIV    = 4'd14;
    localparam logic [3:0] S_PEAK   = 4'd15;

    // control state
    logic [3:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [30:0]          r_p, n_p;
    logic [16:0]          r_pos, n_pos;
    logic [15:0]          r_peak, n_peak;
    logic                 r_clip, n_clip;
    logic                 r_out_valid, n_out_valid;
    logic [15:0]          r_pos_step, n_pos_step;
    logic [15:0]          r_kt, n_kt;
    logic [7:0]           r_gain, n_gain;

    // datapath payload
    logic [AMP_WIDTH-1:0] r_amp, n_amp;
    logic                 r_last, n_last;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [15:0]          r_frac, n_frac;
    logic [15:0]          r_hi, n_hi;
    logic [15:0]          r_w, n_w;
    logic [VW-1:0]        r_v, n_v;
    logic [AMP_WIDTH-1:0] r_e, n_e;
    logic [AMP_WIDTH-1:0] r_ee_hi, n_ee_hi;
    logic [AMP_WIDTH+7:0] r_plo, n_plo;
    logic [15:0]          r_out_peak, n_out_peak;
    logic                 r_out_sat, n_out_sat;

    // exp table memory
    logic [15:0]          r_tab [TAB_N];
    logic [15:0]          r_tab_rd;
    logic                 w_tab_we;
    logic [15:0]          w_tab_wdata;
    logic                 w_tab_re;
    logic [IDX_W-1:0]     w_tab_raddr;

    // shared multiplier
    logic [MUL_W-1:0]     w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0]   w_prod;

    // combinational helpers
    logic [16:0]          w_dist;
    logic [38:0]          w_dd25;
    logic [21:0]          w_t;
    logic [43:0]          w_idx_full;
    logic                 w_far;
    logic [15:0]          w_lo;
    logic [AMP_WIDTH+16:0] w_round;
    logic [AMP_WIDTH-1:0] w_v;
    logic [VW-1:0]        w_v_ext, w_kt_ext;
    logic [BW-1:0]        w_gsum;
    logic [SW-1:0]        w_sum;
    logic [31:0]          w_p_round;
    logic [17:0]          w_p_q16;
    logic [63:0]          w_p_next;
    logic [29:0]          w_q;
    logic [15:0]          w_q16;
    logic                 w_q_clip;
    logic [15:0]          w_new_peak;
    logic [17:0]          w_pos_sum;
    logic                 w_out_free;

    wbpd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // distance from the center and its scaled square
    assign w_dist = (r_pos >= MID_Q16) ? r_pos - MID_Q16 : MID_Q16 - r_pos;
    assign w_dd25 = ({5'd0, w_prod[33:0]} << 4) + ({5'd0, w_prod[33:0]} << 3)
                  + {5'd0, w_prod[33:0]};
    assign w_t    = w_dd25[38:17];

    // table position: integer part from bit 20 up, fraction in [19:4]
    assign w_idx_full = w_prod[63:20];
    assign w_far      = w_idx_full >= 44'(EXP_TABLE_DEPTH);
    assign w_lo       = (r_tab_rd > r_hi) ? r_hi : r_tab_rd;

    // weighted value, rounded to Q8.8
    assign w_round  = w_prod[AMP_WIDTH+16:0] + (AMP_WIDTH+17)'(32768);
    assign w_v      = w_round[AMP_WIDTH+15:16];
    assign w_v_ext  = VW'(w_v);
    assign w_kt_ext = VW'(r_kt);

    // gain product reassembled from its two halves, then added to the threshold
    assign w_gsum = {w_prod[AMP_WIDTH+7:0], {AMP_WIDTH{1'b0}}} + BW'(r_plo);
    assign w_sum  = SW'(w_gsum >> 12) + SW'(r_kt);

    // table build: round p to Q0.16 and renormalize the next power
    assign w_p_round = {1'b0, r_p} + 32'd8192;
    assign w_p_q16   = w_p_round[31:14];
    assign w_p_next  = (w_prod + (64'd1 << 29)) >> 30;

    // divide by 5 and clamp to the output width
    assign w_q        = w_prod[63:34];
    assign w_q_clip   = w_q > 30'd65535;
    assign w_q16      = w_q_clip ? 16'hFFFF : w_q[15:0];
    assign w_new_peak = (w_q16 > r_peak) ? w_q16 : r_peak;
    assign w_pos_sum  = {1'b0, r_pos} + {2'd0, r_pos_step};
    assign w_out_free = !r_out_valid || !i_stall;

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_INIT_A, S_INIT_B: begin
                w_mul_a = MUL_W'(r_p);
                w_mul_b = EXP_RATIO_Q30[MUL_W-1:0];
            end
            S_IDLE: begin
                w_mul_a = MUL_W'(w_dist);
                w_mul_b = MUL_W'(w_dist);
            end
            S_SCALE: begin
                w_mul_a = MUL_W'(w_t);
                w_mul_b = MUL_W'(EXP_TABLE_DEPTH);
            end
            S_RDLO: begin
                w_mul_a = MUL_W'(r_hi - w_lo);
                w_mul_b = MUL_W'(r_frac);
            end
            S_AMP: begin
                w_mul_a = MUL_W'(r_amp);
                w_mul_b = MUL_W'(r_w);
            end
            S_ESQ: begin
                w_mul_a = MUL_W'(r_e);
                w_mul_b = MUL_W'(r_e);
            end
            S_GLO: begin
                w_mul_a = MUL_W'(w_prod[AMP_WIDTH-1:0]);
                w_mul_b = MUL_W'(r_gain);
            end
            S_GHI: begin
                w_mul_a = MUL_W'(r_ee_hi);
                w_mul_b = MUL_W'(r_gain);
            end
            S_DIV, S_PEAK: begin
                w_mul_a = MUL_W'(r_v);
                w_mul_b = RECIP_5;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // table port control
    assign w_tab_we    = (r_state == S_INIT_A);
    assign w_tab_wdata = (w_p_q16 > 18'd65535) ? 16'hFFFF : w_p_q16[15:0];
    assign w_tab_re    = ((r_state == S_IDX) && !w_far) || (r_state == S_RDHI);
    assign w_tab_raddr = (r_state == S_IDX) ? w_prod[20+IDX_W-1:20] : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_tab[r_k] <= w_tab_wdata;
        end
        if (w_tab_re) begin
            r_tab_rd <= r_tab[w_tab_raddr];
        end
    end

    // sequencer and next-state logic
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_p         = r_p;
        n_pos       = r_pos;
        n_peak      = r_peak;
        n_clip      = r_clip;
        n_out_valid = r_out_valid;
        n_pos_step  = r_pos_step;
        n_kt        = r_kt;
        n_gain      = r_gain;
        n_amp       = r_amp;
        n_last      = r_last;
        n_idx       = r_idx;
        n_frac      = r_frac;
        n_hi        = r_hi;
        n_w         = r_w;
        n_v         = r_v;
        n_e         = r_e;
        n_ee_hi     = r_ee_hi;
        n_plo       = r_plo;
        n_out_peak  = r_out_peak;
        n_out_sat   = r_out_sat;

        // output register drains independently
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POSITION_STEP:  n_pos_step = i_cfg_data;
                CFG_KICK_THRESHOLD: n_kt       = i_cfg_data;
                CFG_BOOST_GAIN:     n_gain     = i_cfg_data[7:0];
                default: ;
            endcase
        end

        case (r_state)
            S_INIT_A: begin
                if (r_k == IDX_W'(EXP_TABLE_DEPTH)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_INIT_B;
                end
            end
            S_INIT_B: begin
                n_p     = w_p_next[30:0];
                n_k     = r_k + 1'b1;
                n_state = S_INIT_A;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_amp   = i_amplitude;
                    n_last  = i_last_bin;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_IDX;
            end
            S_IDX: begin
                n_idx  = w_prod[20+IDX_W-1:20];
                n_frac = w_prod[19:4];
                if (w_far) begin
                    n_w     = '0;
                    n_state = S_AMP;
                end else begin
                    n_state = S_RDHI;
                end
            end
            S_RDHI: begin
                n_hi    = r_tab_rd;
                n_state = S_RDLO;
            end
            S_RDLO: begin
                n_state = S_INTERP;
            end
            S_INTERP: begin
                n_w     = r_hi - w_prod[31:16];
                n_state = S_AMP;
            end
            S_AMP: begin
                n_state = S_VAL;
            end
            S_VAL: begin
                n_v = w_v_ext;
                if (w_v_ext > w_kt_ext) begin
                    n_e     = AMP_WIDTH'(w_v_ext - w_kt_ext);
                    n_state = S_ESQ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_ESQ: begin
                n_state = S_GLO;
            end
            S_GLO: begin
                n_ee_hi = w_prod[2*AMP_WIDTH-1:AMP_WIDTH];
                n_state = S_GHI;
            end
            S_GHI: begin
                n_plo   = w_prod[AMP_WIDTH+7:0];
                n_state = S_BOOST;
            end
            S_BOOST: begin
                if (w_sum > SW'(VAL_MAX)) begin
                    n_v    = VW'(VAL_MAX);
                    n_clip = 1'b1;
                end else begin
                    n_v = w_sum[VW-1:0];
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_PEAK;
            end
            S_PEAK: begin
                if (!r_last || w_out_free) begin
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_peak  = w_new_peak;
                        n_out_sat   = n_clip || w_q_clip;
                        n_pos       = '0;
                        n_peak      = '0;
                        n_clip      = 1'b0;
                    end else begin
                        n_peak = w_new_peak;
                        n_clip = n_clip || w_q_clip;
                        n_pos  = (w_pos_sum > {1'b0, POS_MAX}) ? POS_MAX : w_pos_sum[16:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT_A;
            r_k         <= '0;
            r_p         <= ONE_Q30[30:0];
            r_pos       <= '0;
            r_peak      <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_step  <= 16'd2260;
            r_kt        <= 16'd256;
            r_gain      <= 8'd48;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_p         <= n_p;
            r_pos       <= n_pos;
            r_peak      <= n_peak;
            r_clip      <= n_clip;
            r_out_valid <= n_out_valid;
            r_pos_step  <= n_pos_step;
            r_kt        <= n_kt;
            r_gain      <= n_gain;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_amp      <= n_amp;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_frac     <= n_frac;
        r_hi       <= n_hi;
        r_w        <= n_w;
        r_v        <= n_v;
        r_e        <= n_e;
        r_ee_hi    <= n_ee_hi;
        r_plo      <= n_plo;
        r_out_peak <= n_out_peak;
        r_out_sat  <= n_out_sat;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_peak_value = r_out_peak;
    assign o_saturated  = r_out_sat;
    assign o_cfg_ready  = 1'b1;

endmodule
